### rtl/rfwc_pkg.sv
// ----------------------------------------------------------------------------
// rfwc_pkg
// Shared types and codes for the replay fifo with read cursor.
// ----------------------------------------------------------------------------
package rfwc_pkg;

    // operation codes on the op field
    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_DEQUEUE = 3'd1;
    localparam logic [2:0] OP_DROP    = 3'd2;
    localparam logic [2:0] OP_REWIND  = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // configuration register indexes
    localparam logic CFG_KEEP_MODE = 1'b0;
    localparam logic CFG_MAX_COUNT = 1'b1;

    // width and reset value of the count limit register
    localparam int         MAX_COUNT_W   = 5;
    localparam logic [4:0] MAX_COUNT_RST = 5'd16;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        K_NOP    = 3'd0,
        K_ENQ    = 3'd1,
        K_DEQ    = 3'd2,
        K_DROP   = 3'd3,
        K_REWIND = 3'd4,
        K_CLEAR  = 3'd5
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // command control from front to back
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_cmd_ctl;

    // status and flag group of one result
    typedef struct packed {
        t_status status;
        logic    cursor_valid;
        logic    head_valid;
        logic    at_head;
    } t_res_flags;

endpackage

### rtl/replay_fifo_with_cursor.sv
// ----------------------------------------------------------------------------
// replay_fifo_with_cursor
// Bounded word fifo with a separate replay cursor for retransmit buffers.
//
//   channel   handshake         payload
//   ops in    push / full       i_op, i_data_in
//   results   empty / pop       o_read_data, o_status, o_cursor_data,
//                               o_cursor_valid, o_head_data, o_head_valid,
//                               o_at_head, o_fill_count
//   config    i_cfg_we          i_cfg_idx, i_cfg_data (no wait, no read-back)
//
// Each operation passes through the back-end steps command take, execute,
// read of the word store at the new cursor and head, and result emit.
// The word store has registered reads, which sets that sequence.
// Two-entry queues on the op side and the result side let either side stall.
// Reset is synchronous; stored words are not cleared, the count is.
// ----------------------------------------------------------------------------
module replay_fifo_with_cursor import rfwc_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [2:0]             i_op,
    input  logic [DATA_WIDTH-1:0]  i_data_in,
    output logic                   empty,
    input  logic                   pop,
    output logic [DATA_WIDTH-1:0]  o_read_data,
    output logic [1:0]             o_status,
    output logic [DATA_WIDTH-1:0]  o_cursor_data,
    output logic                   o_cursor_valid,
    output logic [DATA_WIDTH-1:0]  o_head_data,
    output logic                   o_head_valid,
    output logic                   o_at_head,
    output logic [$clog2(DEPTH+1)-1:0] o_fill_count,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [MAX_COUNT_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = $bits(t_res_flags);
    localparam int RW = 3 * DATA_WIDTH + FW + CW;

    t_cmd_ctl              cmd;
    logic [DATA_WIDTH-1:0] cmd_data;
    logic                  cmd_take;
    logic                  res_full;
    logic                  res_valid;
    logic [DATA_WIDTH-1:0] res_rd;
    logic [DATA_WIDTH-1:0] res_cur;
    logic [DATA_WIDTH-1:0] res_head;
    t_res_flags            res_flags;
    logic [CW-1:0]         res_cnt;
    logic [RW-1:0]         q_out;
    t_res_flags            out_flags;

    // front end: accept and classify
    rfwc_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_op       (i_op),
        .i_data_in  (i_data_in),
        .o_cmd      (cmd),
        .o_cmd_data (cmd_data),
        .i_cmd_take (cmd_take)
    );

    // back end: store and pointer state
    rfwc_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .CW(CW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_cmd_data    (cmd_data),
        .o_cmd_take    (cmd_take),
        .i_res_space   (!res_full),
        .o_res_valid   (res_valid),
        .o_read_data   (res_rd),
        .o_cursor_data (res_cur),
        .o_head_data   (res_head),
        .o_flags       (res_flags),
        .o_fill_count  (res_cnt)
    );

    // result queue toward the consumer
    rfwc_queue #(.W(RW)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  ({res_rd, res_cur, res_head, res_flags, res_cnt}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    assign o_read_data    = q_out[RW-1 -: DATA_WIDTH];
    assign o_cursor_data  = q_out[RW-DATA_WIDTH-1 -: DATA_WIDTH];
    assign o_head_data    = q_out[RW-2*DATA_WIDTH-1 -: DATA_WIDTH];
    assign out_flags      = t_res_flags'(q_out[CW+FW-1 -: FW]);
    assign o_fill_count   = q_out[CW-1:0];
    assign o_status       = out_flags.status;
    assign o_cursor_valid = out_flags.cursor_valid;
    assign o_head_valid   = out_flags.head_valid;
    assign o_at_head      = out_flags.at_head;

endmodule

### rtl/rfwc_queue.sv
// ----------------------------------------------------------------------------
// rfwc_queue
// Two-entry register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module rfwc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_slot [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         push_ok;
    logic         pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wr <= ~r_wr;
            if (pop_ok)  r_rd <= ~r_rd;
            if (push_ok && !pop_ok)      r_cnt <= r_cnt + 2'd1;
            else if (pop_ok && !push_ok) r_cnt <= r_cnt - 2'd1;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (push_ok) r_slot[r_wr] <= i_data;
    end

endmodule

### rtl/rfwc_front.sv
// ----------------------------------------------------------------------------
// rfwc_front
// Accepts operation beats, classifies the op code and queues the command.
// ----------------------------------------------------------------------------
module rfwc_front import rfwc_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            i_op,
    input  logic [DATA_WIDTH-1:0] i_data_in,
    output t_cmd_ctl              o_cmd,
    output logic [DATA_WIDTH-1:0] o_cmd_data,
    input  logic                  i_cmd_take
);

    localparam int KW = $bits(t_kind);
    localparam int QW = KW + DATA_WIDTH;

    t_kind         kind;
    logic [QW-1:0] q_out;
    logic          q_empty;

    // op decode, unused codes become no-ops
    always_comb begin
        unique case (i_op)
            OP_ENQUEUE: kind = K_ENQ;
            OP_DEQUEUE: kind = K_DEQ;
            OP_DROP:    kind = K_DROP;
            OP_REWIND:  kind = K_REWIND;
            OP_CLEAR:   kind = K_CLEAR;
            default:    kind = K_NOP;
        endcase
    end

    // command queue toward the back end
    rfwc_queue #(.W(QW)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({kind, i_data_in}),
        .o_full  (full),
        .i_pop   (i_cmd_take),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign o_cmd.valid = !q_empty;
    assign o_cmd.kind  = t_kind'(q_out[QW-1 -: KW]);
    assign o_cmd_data  = q_out[DATA_WIDTH-1:0];

endmodule

### rtl/rfwc_back.sv
// ----------------------------------------------------------------------------
// rfwc_back
// Word store, head/cursor/count state and the per-operation sequencer.
// ----------------------------------------------------------------------------
module rfwc_back import rfwc_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [MAX_COUNT_W-1:0] i_cfg_data,
    input  t_cmd_ctl               i_cmd,
    input  logic [DATA_WIDTH-1:0]  i_cmd_data,
    output logic                   o_cmd_take,
    input  logic                   i_res_space,
    output logic                   o_res_valid,
    output logic [DATA_WIDTH-1:0]  o_read_data,
    output logic [DATA_WIDTH-1:0]  o_cursor_data,
    output logic [DATA_WIDTH-1:0]  o_head_data,
    output t_res_flags             o_flags,
    output logic [CW-1:0]          o_fill_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = CW + 1;
    localparam int MW = (CW > MAX_COUNT_W) ? CW : MAX_COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_VIEW = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [DATA_WIDTH-1:0]  r_mem [DEPTH];
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_cur, n_cur;
    logic                   r_keep;
    logic [MAX_COUNT_W-1:0] r_max;
    t_kind                  r_kind;
    logic [DATA_WIDTH-1:0]  r_data;
    logic [DATA_WIDTH-1:0]  r_rd_cur;
    logic [DATA_WIDTH-1:0]  r_rd_head;
    logic [DATA_WIDTH-1:0]  r_res_rd, n_res_rd;
    t_status                r_res_st, n_res_st;
    logic                   wr_en;
    logic [AW-1:0]          wr_slot;
    logic                   at_limit;
    logic                   cur_ok;
    logic                   head_ok;

    // ring position of an offset from the head
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
        return sum[AW-1:0];
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
            r_max  <= MAX_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEEP_MODE: r_keep <= i_cfg_data[0];
                CFG_MAX_COUNT: r_max  <= i_cfg_data;
            endcase
        end
    end

    // sequencer
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd.valid && i_res_space;

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = o_cmd_take ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_VIEW;
            S_VIEW:  n_state = S_EMIT;
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_kind <= i_cmd.kind;
            r_data <= i_cmd_data;
        end
    end

    // operation execute
    assign at_limit = (MW'(r_count) >= MW'(r_max)) || (r_count >= CW'(DEPTH));

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_cur    = r_cur;
        n_res_rd = '0;
        n_res_st = ST_DONE;
        wr_en    = 1'b0;
        wr_slot  = slot_of(r_head, r_count);
        unique case (r_kind)
            K_ENQ: begin
                if (at_limit) begin
                    n_res_st = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            K_DEQ: begin
                if (r_cur >= r_count) begin
                    n_res_st = ST_EMPTY;
                end else begin
                    n_res_rd = r_rd_cur;
                    if (r_keep) begin
                        n_cur = r_cur + CW'(1);
                    end else begin
                        n_head  = slot_of(r_head, r_cur + CW'(1));
                        n_count = r_count - r_cur - CW'(1);
                        n_cur   = '0;
                    end
                end
            end
            K_DROP: begin
                if (r_count == '0) begin
                    n_res_st = ST_EMPTY;
                end else begin
                    n_res_rd = r_rd_head;
                    n_head   = slot_of(r_head, CW'(1));
                    n_count  = r_count - CW'(1);
                    if (r_cur != '0) n_cur = r_cur - CW'(1);
                end
            end
            K_REWIND: n_cur = '0;
            K_CLEAR: begin
                n_head  = '0;
                n_count = '0;
                n_cur   = '0;
            end
            K_NOP: ;
            default: ;
        endcase
    end

    // pointer state and result status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cur   <= '0;
        end else if (r_state == S_EXEC) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_cur   <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_res_rd <= n_res_rd;
            r_res_st <= n_res_st;
        end
    end

    // word store: one write port, reads at cursor and head every cycle
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && wr_en) r_mem[wr_slot] <= r_data;
        r_rd_cur  <= r_mem[slot_of(r_head, r_cur)];
        r_rd_head <= r_mem[r_head];
    end

    // result view after the operation
    assign cur_ok  = (r_cur < r_count);
    assign head_ok = (r_count != '0);

    assign o_res_valid          = (r_state == S_EMIT);
    assign o_read_data          = r_res_rd;
    assign o_cursor_data        = cur_ok ? r_rd_cur : '0;
    assign o_head_data          = head_ok ? r_rd_head : '0;
    assign o_flags.status       = r_res_st;
    assign o_flags.cursor_valid = cur_ok;
    assign o_flags.head_valid   = head_ok;
    assign o_flags.at_head      = (r_cur == '0);
    assign o_fill_count         = r_count;

endmodule

### rtl/rfwc_checker.sv
// ----------------------------------------------------------------------------
// rfwc_checker
// Port-level assertions for the replay fifo, bound to the top level.
// ----------------------------------------------------------------------------
module rfwc_checker import rfwc_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   empty,
    input logic                   pop,
    input logic [DATA_WIDTH-1:0]  o_read_data,
    input logic [1:0]             o_status,
    input logic [DATA_WIDTH-1:0]  o_cursor_data,
    input logic                   o_cursor_valid,
    input logic [DATA_WIDTH-1:0]  o_head_data,
    input logic                   o_head_valid,
    input logic                   o_at_head,
    input logic [$clog2(DEPTH+1)-1:0] o_fill_count
);

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // head valid tracks a nonzero count
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_head_valid == (o_fill_count != '0)))
        else $error("head_valid disagrees with fill_count");

    // a cursor at the head shows the head word
    a_at_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_at_head && o_cursor_valid) |-> (o_cursor_data == o_head_data))
        else $error("cursor word at the head differs from head word");

    // refusals return no word
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != ST_DONE)) |-> (o_read_data == '0))
        else $error("refused operation returned data");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_read_data) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind replay_fifo_with_cursor rfwc_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_rfwc_checker (.*);
